// ===== rtl/ffba_pkg.sv =====
// Package for the first-fit block allocator: constants, codes and transfer types.
package ffba_pkg;

    localparam int C_POOL_BYTES  = 65536;
    localparam int C_HDR_BYTES   = 24;
    localparam int C_MIN_SPLIT   = 16;
    localparam int C_MAX_BLOCKS  = 64;
    localparam int C_SW          = $clog2(C_MAX_BLOCKS);
    localparam int C_LW          = C_SW + 1;
    localparam int C_AW          = 17;

    localparam logic [C_LW-1:0] C_NIL = C_LW'(C_MAX_BLOCKS);

    localparam logic [1:0] C_FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] C_FUNC_FREE   = 2'd1;
    localparam logic [1:0] C_FUNC_RESIZE = 2'd2;

    localparam logic [1:0] C_ST_OK      = 2'd0;
    localparam logic [1:0] C_ST_NOFIT   = 2'd1;
    localparam logic [1:0] C_ST_BADPTR  = 2'd2;

    typedef struct packed {
        logic [1:0]      func;
        logic [C_AW-1:0] req_size;
        logic [C_AW-1:0] addr;
        logic            has_pointer;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [C_AW-1:0] result_addr;
        logic            moved;
    } t_rsp;

    typedef struct packed {
        logic [C_AW-1:0] offset;
        logic [C_AW-1:0] size;
        logic            is_free;
        logic [C_LW-1:0] link;
    } t_ent;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_RD, S_A_EV, S_A_POP, S_A_SPL, S_FB_W,
        S_F_RD, S_F_EV, S_R_NX, S_C_RD, S_C_EV, S_C_NX, S_FIN
    } t_state;

endpackage

// ===== rtl/ffba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// Top level of the first-fit block allocator with split and coalesce.
// One request is handled at a time. The block list lives in a 64-entry table RAM
// and is walked one node at a time (RAM read, then evaluate), so the time a
// request takes grows with the list nodes visited: allocate and find walk up to 64
// nodes, and free or a moving resize adds a full coalesce walk from the head.
// A split adds the S_A_POP and S_A_SPL states. A pool size write rebuilds the list in S_INIT.
// The spare-slot stack is a second RAM; entries not pushed since the last rebuild are
// never read, as their slot number is derived from the stack count, so no clearing pass is needed.
module first_fit_block_allocator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ffba_pkg::t_req     i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ffba_pkg::t_rsp     o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ffba_pkg::C_AW-1:0] i_cfg_data
);

    localparam int SW = ffba_pkg::C_SW;
    localparam int LW = ffba_pkg::C_LW;
    localparam int AW = ffba_pkg::C_AW;
    localparam int EW = $bits(ffba_pkg::t_ent);
    localparam logic [AW-1:0] HDR   = AW'(ffba_pkg::C_HDR_BYTES);
    localparam logic [AW-1:0] SPLIT = AW'(ffba_pkg::C_HDR_BYTES + ffba_pkg::C_MIN_SPLIT);
    localparam logic [AW-1:0] POOL  = AW'(ffba_pkg::C_POOL_BYTES);
    localparam logic [LW-1:0] MAXB  = LW'(ffba_pkg::C_MAX_BLOCKS);
    localparam logic [SW-1:0] TOP   = SW'(ffba_pkg::C_MAX_BLOCKS - 1);

    ffba_pkg::t_state r_state, n_state;
    ffba_pkg::t_req   r_req, n_req;
    ffba_pkg::t_rsp   r_res, n_res;
    ffba_pkg::t_rsp   r_out, n_out;
    ffba_pkg::t_ent   r_cd, n_cd;
    ffba_pkg::t_ent   r_bd, n_bd;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_b, n_b;
    logic [LW-1:0]    r_head, n_head;
    logic [LW-1:0]    r_cnt, n_cnt;
    logic [LW-1:0]    r_lo, n_lo;
    logic [SW-1:0]    r_s, n_s;
    logic [AW-1:0]    r_pool, n_pool;
    logic             r_resz, n_resz;
    logic             r_ov, n_ov;

    logic             t_we;
    logic [SW-1:0]    t_wa, t_ra;
    ffba_pkg::t_ent   t_wd, t_rd;
    logic [EW-1:0]    t_rd_raw;
    logic             s_we;
    logic [SW-1:0]    s_wa, s_ra;
    logic [SW-1:0]    s_wd, s_rd;

    logic [AW:0]      sum_hdr;
    logic [AW:0]      sum_fit;
    logic [AW:0]      sum_mrg;
    logic [AW-1:0]    rem;
    logic [SW-1:0]    pop_slot;
    logic [AW-1:0]    cfg_pool;
    ffba_pkg::t_ent   ent_new;
    logic             do_push;
    logic [SW-1:0]    push_slot;

    ffba_ram #(.WIDTH(EW), .DEPTH(ffba_pkg::C_MAX_BLOCKS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_wa),
        .i_wdata (t_wd),
        .i_raddr (t_ra),
        .o_rdata (t_rd_raw)
    );
    assign t_rd = ffba_pkg::t_ent'(t_rd_raw);

    ffba_ram #(.WIDTH(SW), .DEPTH(ffba_pkg::C_MAX_BLOCKS)) u_stk (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_wa),
        .i_wdata (s_wd),
        .i_raddr (s_ra),
        .o_rdata (s_rd)
    );

    assign o_in_stall  = (r_state != ffba_pkg::S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == ffba_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign cfg_pool = (i_cfg_data > POOL) ? POOL : i_cfg_data;
    assign pop_slot = (r_cnt < r_lo) ? (TOP - r_cnt[SW-1:0]) : s_rd;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_res   = r_res;
        n_out   = r_out;
        n_cd    = r_cd;
        n_bd    = r_bd;
        n_cur   = r_cur;
        n_b     = r_b;
        n_head  = r_head;
        n_cnt   = r_cnt;
        n_lo    = r_lo;
        n_s     = r_s;
        n_pool  = r_pool;
        n_resz  = r_resz;
        n_ov    = r_ov && i_out_stall;
        t_we    = 1'b0;
        t_wa    = r_cur[SW-1:0];
        t_wd    = r_cd;
        t_ra    = r_cur[SW-1:0];
        s_we    = 1'b0;
        s_wa    = r_cnt[SW-1:0];
        s_wd    = '0;
        s_ra    = SW'(r_cnt - LW'(1));
        do_push = 1'b0;
        push_slot = '0;
        sum_hdr = '0;
        sum_fit = '0;
        sum_mrg = '0;
        rem     = '0;
        ent_new = r_cd;

        case (r_state)
            ffba_pkg::S_INIT: begin
                n_lo = MAXB;
                if (r_pool >= HDR) begin
                    t_we = 1'b1;
                    t_wa = '0;
                    t_wd = '{offset: '0, size: r_pool - HDR, is_free: 1'b1,
                             link: ffba_pkg::C_NIL};
                    n_head = '0;
                    n_cnt  = MAXB - LW'(1);
                end else begin
                    n_head = ffba_pkg::C_NIL;
                    n_cnt  = MAXB;
                end
                n_state = ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_IDLE: begin
                if (i_cfg_valid) begin
                    n_pool  = cfg_pool;
                    n_state = ffba_pkg::S_INIT;
                end else if (i_in_valid) begin
                    n_req  = i_in_data;
                    n_cur  = r_head;
                    n_resz = 1'b0;
                    n_res  = '{status: ffba_pkg::C_ST_NOFIT, result_addr: '0, moved: 1'b0};
                    case (i_in_data.func)
                        ffba_pkg::C_FUNC_ALLOC: n_state = ffba_pkg::S_A_RD;
                        ffba_pkg::C_FUNC_FREE: begin
                            if (i_in_data.has_pointer) begin
                                n_state = ffba_pkg::S_F_RD;
                            end else begin
                                n_res.status = ffba_pkg::C_ST_OK;
                                n_state = ffba_pkg::S_FIN;
                            end
                        end
                        ffba_pkg::C_FUNC_RESIZE: begin
                            n_state = i_in_data.has_pointer ? ffba_pkg::S_F_RD
                                                            : ffba_pkg::S_A_RD;
                        end
                        default: n_state = ffba_pkg::S_FIN;
                    endcase
                end
            end
            ffba_pkg::S_A_RD: begin
                if (r_cur == ffba_pkg::C_NIL) begin
                    n_res   = '{status: ffba_pkg::C_ST_NOFIT, result_addr: '0, moved: 1'b0};
                    n_state = ffba_pkg::S_FIN;
                end else begin
                    n_state = ffba_pkg::S_A_EV;
                end
            end
            ffba_pkg::S_A_EV: begin
                n_cd = t_rd;
                rem  = t_rd.size - r_req.req_size;
                if (t_rd.is_free && (t_rd.size >= r_req.req_size)) begin
                    sum_hdr = {1'b0, t_rd.offset} + {1'b0, HDR};
                    n_res   = '{status: ffba_pkg::C_ST_OK, result_addr: sum_hdr[AW-1:0],
                                moved: r_resz};
                    if ((rem >= SPLIT) && (r_cnt != '0)) begin
                        n_cnt   = r_cnt - LW'(1);
                        n_state = ffba_pkg::S_A_POP;
                    end else begin
                        t_we    = 1'b1;
                        t_wd    = t_rd;
                        t_wd.is_free = 1'b0;
                        n_state = r_resz ? ffba_pkg::S_FB_W : ffba_pkg::S_FIN;
                    end
                end else begin
                    n_cur   = t_rd.link;
                    n_state = ffba_pkg::S_A_RD;
                end
            end
            ffba_pkg::S_A_POP: begin
                sum_fit = {1'b0, r_cd.offset} + {1'b0, HDR} + {1'b0, r_req.req_size};
                rem     = r_cd.size - r_req.req_size;
                t_we    = 1'b1;
                t_wa    = pop_slot;
                t_wd    = '{offset: sum_fit[AW-1:0], size: rem - HDR, is_free: 1'b1,
                            link: r_cd.link};
                n_s     = pop_slot;
                n_state = ffba_pkg::S_A_SPL;
            end
            ffba_pkg::S_A_SPL: begin
                t_we    = 1'b1;
                t_wd    = '{offset: r_cd.offset, size: r_req.req_size, is_free: 1'b0,
                            link: {1'b0, r_s}};
                n_state = r_resz ? ffba_pkg::S_FB_W : ffba_pkg::S_FIN;
            end
            ffba_pkg::S_FB_W: begin
                t_we    = 1'b1;
                t_wa    = r_b[SW-1:0];
                t_wd    = r_bd;
                t_wd.is_free = 1'b1;
                n_cur   = r_head;
                n_state = ffba_pkg::S_C_RD;
            end
            ffba_pkg::S_F_RD: begin
                if (r_cur == ffba_pkg::C_NIL) begin
                    n_res   = '{status: ffba_pkg::C_ST_BADPTR, result_addr: '0, moved: 1'b0};
                    n_state = ffba_pkg::S_FIN;
                end else begin
                    n_state = ffba_pkg::S_F_EV;
                end
            end
            ffba_pkg::S_F_EV: begin
                sum_hdr = {1'b0, t_rd.offset} + {1'b0, HDR};
                if (!t_rd.is_free && (sum_hdr == {1'b0, r_req.addr})) begin
                    n_b  = r_cur;
                    n_bd = t_rd;
                    if (r_req.func == ffba_pkg::C_FUNC_FREE) begin
                        n_res   = '{status: ffba_pkg::C_ST_OK, result_addr: '0, moved: 1'b0};
                        n_state = ffba_pkg::S_FB_W;
                    end else if (t_rd.size >= r_req.req_size) begin
                        n_res   = '{status: ffba_pkg::C_ST_OK, result_addr: r_req.addr,
                                    moved: 1'b0};
                        n_state = ffba_pkg::S_FIN;
                    end else if (t_rd.link != ffba_pkg::C_NIL) begin
                        t_ra    = t_rd.link[SW-1:0];
                        n_state = ffba_pkg::S_R_NX;
                    end else begin
                        n_resz  = 1'b1;
                        n_cur   = r_head;
                        n_state = ffba_pkg::S_A_RD;
                    end
                end else begin
                    n_cur   = t_rd.link;
                    n_state = ffba_pkg::S_F_RD;
                end
            end
            ffba_pkg::S_R_NX: begin
                sum_fit = {1'b0, r_bd.size} + {1'b0, t_rd.size};
                if (t_rd.is_free && (sum_fit >= {1'b0, r_req.req_size})) begin
                    sum_mrg = sum_fit + {1'b0, HDR};
                    t_we    = 1'b1;
                    t_wa    = r_b[SW-1:0];
                    t_wd    = '{offset: r_bd.offset, size: sum_mrg[AW-1:0], is_free: 1'b0,
                                link: t_rd.link};
                    do_push   = 1'b1;
                    push_slot = r_bd.link[SW-1:0];
                    n_res   = '{status: ffba_pkg::C_ST_OK, result_addr: r_req.addr,
                                moved: 1'b0};
                    n_state = ffba_pkg::S_FIN;
                end else begin
                    n_resz  = 1'b1;
                    n_cur   = r_head;
                    n_state = ffba_pkg::S_A_RD;
                end
            end
            ffba_pkg::S_C_RD: begin
                n_state = (r_cur == ffba_pkg::C_NIL) ? ffba_pkg::S_FIN : ffba_pkg::S_C_EV;
            end
            ffba_pkg::S_C_EV: begin
                n_cd = t_rd;
                if (t_rd.is_free && (t_rd.link != ffba_pkg::C_NIL)) begin
                    t_ra    = t_rd.link[SW-1:0];
                    n_state = ffba_pkg::S_C_NX;
                end else begin
                    n_cur   = t_rd.link;
                    n_state = ffba_pkg::S_C_RD;
                end
            end
            ffba_pkg::S_C_NX: begin
                if (t_rd.is_free) begin
                    sum_mrg = {1'b0, r_cd.size} + {1'b0, t_rd.size} + {1'b0, HDR};
                    ent_new = '{offset: r_cd.offset, size: sum_mrg[AW-1:0], is_free: 1'b1,
                                link: t_rd.link};
                    t_we    = 1'b1;
                    t_wd    = ent_new;
                    n_cd    = ent_new;
                    do_push   = 1'b1;
                    push_slot = r_cd.link[SW-1:0];
                    if (t_rd.link != ffba_pkg::C_NIL) begin
                        t_ra    = t_rd.link[SW-1:0];
                        n_state = ffba_pkg::S_C_NX;
                    end else begin
                        n_state = ffba_pkg::S_FIN;
                    end
                end else begin
                    n_cur   = t_rd.link;
                    n_state = ffba_pkg::S_C_RD;
                end
            end
            ffba_pkg::S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase

        if (do_push && (r_cnt < MAXB)) begin
            s_we  = 1'b1;
            s_wa  = r_cnt[SW-1:0];
            s_wd  = push_slot;
            n_cnt = r_cnt + LW'(1);
            if (r_cnt < r_lo) begin
                n_lo = r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_INIT;
            r_pool  <= POOL;
            r_ov    <= 1'b0;
            r_head  <= ffba_pkg::C_NIL;
            r_cnt   <= '0;
            r_lo    <= MAXB;
            r_resz  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_ov    <= n_ov;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_lo    <= n_lo;
            r_resz  <= n_resz;
        end
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
        r_cd  <= n_cd;
        r_bd  <= n_bd;
        r_cur <= n_cur;
        r_b   <= n_b;
        r_s   <= n_s;
    end

endmodule

// ===== test/first_fit_block_allocator_unit_tb.sv =====
// Testbench for the first-fit block allocator: predicted responses vs. DUT responses.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit_tb;

    localparam int NSLOT = ffba_pkg::C_MAX_BLOCKS;
    localparam int NIL = ffba_pkg::C_MAX_BLOCKS;
    localparam int AW = ffba_pkg::C_AW;
    localparam int HDR = ffba_pkg::C_HDR_BYTES;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    ffba_pkg::t_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    ffba_pkg::t_rsp o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [AW-1:0] i_cfg_data;

    first_fit_block_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // allocator shadow state
    int unsigned m_off [NSLOT];
    int unsigned m_size [NSLOT];
    bit m_free [NSLOT];
    int unsigned m_link [NSLOT];
    int unsigned m_head;
    int unsigned m_stack [NSLOT];
    int unsigned m_spare;
    int unsigned live_addrs [$];

    ffba_pkg::t_req pending_reqs [$];
    ffba_pkg::t_rsp expected_rsps [$];
    int errors = 0;
    int hold_cycles = 0;
    int sender_gap = 0;
    int recv_gap = 0;
    bit sender_pause = 0;

    function automatic void rebuild_pool(int unsigned pool_cfg);
        int unsigned p;
        p = (pool_cfg > ffba_pkg::C_POOL_BYTES) ? ffba_pkg::C_POOL_BYTES : pool_cfg;
        for (int i = 0; i < NSLOT; i++) begin
            m_off[i] = 0; m_size[i] = 0; m_free[i] = 0; m_link[i] = NIL;
            m_stack[i] = NSLOT - 1 - i;
        end
        if (p >= HDR) begin
            m_head = 0; m_size[0] = p - HDR; m_free[0] = 1; m_spare = NSLOT - 1;
        end else begin
            m_head = NIL; m_spare = NSLOT;
        end
    endfunction

    function automatic void release_slot(int unsigned s);
        if (m_spare < NSLOT) begin
            m_stack[m_spare] = s;
            m_spare++;
        end
    endfunction

    function automatic int unsigned locate_used(int unsigned a);
        int unsigned cur = m_head;
        for (int st = 0; st < NSLOT && cur < NIL; st++) begin
            if (!m_free[cur] && m_off[cur] + HDR == a) return cur;
            cur = m_link[cur];
        end
        return NIL;
    endfunction

    function automatic void merge_free_runs();
        int unsigned cur = m_head;
        int unsigned nx;
        for (int st = 0; st < 2 * NSLOT && cur < NIL; st++) begin
            nx = m_link[cur];
            if (m_free[cur] && nx < NIL && m_free[nx]) begin
                m_size[cur] += m_size[nx] + HDR;
                m_link[cur] = m_link[nx];
                m_link[nx] = NIL;
                m_free[nx] = 0;
                release_slot(nx);
            end else begin
                cur = nx;
            end
        end
    endfunction

    function automatic bit first_fit(int unsigned req, output int unsigned a);
        int unsigned cur = m_head;
        int unsigned rem, s;
        a = 0;
        for (int st = 0; st < NSLOT && cur < NIL; st++) begin
            if (m_free[cur] && m_size[cur] >= req) begin
                rem = m_size[cur] - req;
                if (rem >= ffba_pkg::C_MIN_SPLIT + HDR && m_spare > 0) begin
                    m_spare--;
                    s = m_stack[m_spare];
                    if (s < NIL) begin
                        m_off[s] = m_off[cur] + HDR + req;
                        m_size[s] = rem - HDR;
                        m_free[s] = 1;
                        m_link[s] = m_link[cur];
                        m_link[cur] = s;
                        m_size[cur] = req;
                    end
                end
                m_free[cur] = 0;
                a = m_off[cur] + HDR;
                return 1;
            end
            cur = m_link[cur];
        end
        return 0;
    endfunction

    function automatic ffba_pkg::t_rsp predict_alloc(ffba_pkg::t_req r);
        ffba_pkg::t_rsp o;
        int unsigned req = r.req_size, a = r.addr, b, nx, na;
        o.status = ffba_pkg::C_ST_NOFIT; o.result_addr = '0; o.moved = 1'b0;
        if (r.func == ffba_pkg::C_FUNC_ALLOC ||
            (r.func == ffba_pkg::C_FUNC_RESIZE && !r.has_pointer)) begin
            if (first_fit(req, na)) begin
                o.status = ffba_pkg::C_ST_OK; o.result_addr = AW'(na);
            end
        end else if (r.func == ffba_pkg::C_FUNC_FREE) begin
            if (!r.has_pointer) o.status = ffba_pkg::C_ST_OK;
            else begin
                b = locate_used(a);
                if (b >= NIL) o.status = ffba_pkg::C_ST_BADPTR;
                else begin
                    m_free[b] = 1; merge_free_runs(); o.status = ffba_pkg::C_ST_OK;
                end
            end
        end else if (r.func == ffba_pkg::C_FUNC_RESIZE) begin
            b = locate_used(a);
            if (b >= NIL) o.status = ffba_pkg::C_ST_BADPTR;
            else if (m_size[b] >= req) begin
                o.status = ffba_pkg::C_ST_OK; o.result_addr = AW'(a);
            end else begin
                nx = m_link[b];
                if (nx < NIL && m_free[nx] && m_size[b] + m_size[nx] >= req) begin
                    m_size[b] += m_size[nx] + HDR;
                    m_link[b] = m_link[nx];
                    m_link[nx] = NIL;
                    m_free[nx] = 0;
                    release_slot(nx);
                    o.status = ffba_pkg::C_ST_OK; o.result_addr = AW'(a);
                end else if (first_fit(req, na)) begin
                    m_free[b] = 1; merge_free_runs();
                    o.status = ffba_pkg::C_ST_OK; o.result_addr = AW'(na); o.moved = 1'b1;
                end
            end
        end
        return o;
    endfunction

    // keep a list of addresses believed live, to aim frees/resizes at real blocks
    function automatic void track_addr(ffba_pkg::t_req r, ffba_pkg::t_rsp o);
        if (o.status == ffba_pkg::C_ST_OK && o.result_addr != 0) begin
            if (r.func == ffba_pkg::C_FUNC_RESIZE && r.has_pointer && o.moved) begin
                foreach (live_addrs[i]) if (live_addrs[i] == r.addr) begin
                    live_addrs.delete(i); break;
                end
            end
            live_addrs.push_back(o.result_addr);
        end
        if (r.func == ffba_pkg::C_FUNC_FREE && r.has_pointer &&
            o.status == ffba_pkg::C_ST_OK) begin
            foreach (live_addrs[i]) if (live_addrs[i] == r.addr) begin
                live_addrs.delete(i); break;
            end
        end
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // driver
    always @(posedge i_clk) begin
        ffba_pkg::t_req r;
        ffba_pkg::t_rsp o;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r = pending_reqs.pop_front();
            o = predict_alloc(r);
            expected_rsps.push_back(o);
            track_addr(r, o);
            sender_gap = $urandom_range(0, 3);
            if (pending_reqs.size() > 0 && sender_gap == 0 && !sender_pause) begin
                i_in_data <= pending_reqs[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (sender_gap > 0) sender_gap--;
            else if (pending_reqs.size() > 0 && !sender_pause) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_reqs[0];
            end
        end
    end

    // receiver stall and response check
    always @(posedge i_clk) begin
        ffba_pkg::t_rsp e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, o_out_data);
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_out_data.status !== e.status)
                        $display("%0t: status exp %0d got %0d", $time, e.status,
                                 o_out_data.status);
                    if (o_out_data.result_addr !== e.result_addr)
                        $display("%0t: result_addr exp %0d got %0d", $time,
                                 e.result_addr, o_out_data.result_addr);
                    if (o_out_data.moved !== e.moved)
                        $display("%0t: moved exp %0d got %0d", $time, e.moved,
                                 o_out_data.moved);
                    if (o_out_data !== e) errors++;
                end
                recv_gap = $urandom_range(0, 3);
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (recv_gap > 0);
            end
        end
    end

    function automatic ffba_pkg::t_req make_req(int unsigned f, int unsigned sz,
                                                int unsigned a, int unsigned p);
        ffba_pkg::t_req r;
        r.func = 2'(f); r.req_size = AW'(sz); r.addr = AW'(a); r.has_pointer = 1'(p);
        return r;
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 131071);
            1: return $urandom_range(0, 65536);
            2, 3: return $urandom_range(0, 40);
            default: return $urandom_range(1, 1500);
        endcase
    endfunction

    function automatic ffba_pkg::t_req random_req();
        int unsigned k = $urandom_range(0, 99);
        int unsigned a;
        if (live_addrs.size() > 0) a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        else a = $urandom_range(0, 131071);
        if (k < 45) return make_req(ffba_pkg::C_FUNC_ALLOC, pick_size(),
                                    $urandom_range(0, 131071), $urandom_range(0, 1));
        if (k < 75) return make_req(ffba_pkg::C_FUNC_FREE, 0, a, 1);
        if (k < 90) return make_req(ffba_pkg::C_FUNC_RESIZE, pick_size(), a, 1);
        if (k < 94) return make_req(ffba_pkg::C_FUNC_RESIZE, pick_size(), 0, 0);
        if (k < 97) return make_req($urandom_range(0, 3), $urandom_range(0, 131071),
                                    $urandom_range(0, 131071), $urandom_range(0, 1));
        return make_req(ffba_pkg::C_FUNC_FREE, 0, $urandom_range(0, 131071),
                        $urandom_range(0, 1));
    endfunction

    task automatic drain_all();
        wait (pending_reqs.size() == 0 && !i_in_valid);
        while (expected_rsps.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_pool(int unsigned v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= AW'(v);
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rebuild_pool(v);
        live_addrs.delete();
    endtask

    // feeds requests one by one so the live-address list stays current
    task automatic run_random(int n);
        ffba_pkg::t_req r;
        for (int i = 0; i < n; i++) begin
            r = random_req();
            pending_reqs.push_back(r);
            wait (pending_reqs.size() == 0);
            @(negedge i_clk);
        end
    endtask

    initial begin
        int unsigned pools [6];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        rebuild_pool(65536);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 0, 0, 0));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 100, 0, 0));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 131071, 131071, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 65536, 0, 0));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 50, 48, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 200, 48, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 30, 0, 0));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 5000, 48, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_FREE, 0, 48, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_FREE, 0, 48, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_FREE, 0, 77, 0));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_FREE, 0, 131071, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 10, 131071, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 64, 0, 0));
        pending_reqs.push_back(make_req(3, 131071, 131071, 1));
        pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_RESIZE, 131071, 24, 1));
        drain_all();

        // many small blocks to run out of spare slots
        for (int i = 0; i < 70; i++)
            pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC, 8, 0, 0));
        sender_pause = 0;
        hold_cycles = 400;
        drain_all();

        pools[0] = 0; pools[1] = 23; pools[2] = 24; pools[3] = 300;
        pools[4] = 131071; pools[5] = 4096;
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(pools[ph]);
            for (int i = 0; i < 6; i++)
                pending_reqs.push_back(make_req(ffba_pkg::C_FUNC_ALLOC,
                                                $urandom_range(0, 40), 0, 0));
            drain_all();
        end

        write_pool(65536);
        run_random(600);
        drain_all();
        sender_pause = 1;
        repeat (20) @(posedge i_clk);
        sender_pause = 0;
        write_pool(2000);
        run_random(400);
        drain_all();
        write_pool(65536);
        hold_cycles = 300;
        run_random(500);
        drain_all();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== first_fit_block_allocator_unit.f =====
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/first_fit_block_allocator_unit.sv
test/first_fit_block_allocator_unit_tb.sv
